### src/teo_pkg.sv
// Shared types and constants for the two-axis encoder odometry block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package teo_pkg;

    localparam int TEO_CNT_W   = 32;
    localparam int TEO_TOT_W   = 48;
    localparam int TEO_MUL_AW  = 49;
    localparam int TEO_MUL_BW  = 17;
    localparam int TEO_MUL_PW  = TEO_MUL_AW + TEO_MUL_BW;

    localparam logic [32:0] TEO_RAW_COUNT_RANGE = 33'd16777216;

    localparam logic [7:0] TEO_LEN_POS = 8'd7;
    localparam logic [7:0] TEO_CMD_POS = 8'd1;

    typedef enum logic [2:0] {
        REG_AXIS_BUSES = 3'd0,
        REG_X_NODE     = 3'd1,
        REG_Y_NODE     = 3'd2,
        REG_MPC        = 3'd3,
        REG_COS_X      = 3'd4,
        REG_SIN_X      = 3'd5,
        REG_COS_Y      = 3'd6,
        REG_SIN_Y      = 3'd7
    } teo_reg_t;

    typedef struct packed {
        logic taken;
        logic axis;
    } teo_match_t;

endpackage

### src/teo_mul.sv
// Shared signed multiplier with a registered product.
// Depends on teo_pkg for operand widths.
`timescale 1ns / 1ps

module teo_mul
    import teo_pkg::*;
(
    input  logic                          clk,
    input  logic signed [TEO_MUL_AW-1:0]  a,
    input  logic signed [TEO_MUL_BW-1:0]  b,
    output logic signed [TEO_MUL_PW-1:0]  p
);

    logic signed [TEO_MUL_PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### src/teo_track.sv
// Frame matching and per-axis count tracking: wrap-corrected delta and
// saturating 48-bit totals. Depends on teo_pkg.
`timescale 1ns / 1ps

module teo_track
    import teo_pkg::*;
#(
    parameter logic [32:0] RAW_COUNT_RANGE = TEO_RAW_COUNT_RANGE
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        commit,
    input  logic                        bus,
    input  logic [10:0]                 frame_id,
    input  logic [7:0]                  length_byte,
    input  logic [7:0]                  node_byte,
    input  logic [7:0]                  command_byte,
    input  logic [TEO_CNT_W-1:0]        raw_count,
    input  logic [1:0]                  axis_buses,
    input  logic [7:0]                  x_node,
    input  logic [7:0]                  y_node,
    output teo_match_t                  match,
    output logic signed [TEO_TOT_W-1:0] total_x,
    output logic signed [TEO_TOT_W-1:0] total_y
);

    localparam logic signed [33:0] RANGE_S = signed'({1'b0, RAW_COUNT_RANGE});
    localparam logic signed [33:0] HALF_S  = signed'({2'b00, RAW_COUNT_RANGE[32:1]});

    logic                        seen_reg [2];
    logic [TEO_CNT_W-1:0]        last_reg [2];
    logic signed [TEO_TOT_W-1:0] total_reg [2];
    teo_match_t                  match_reg;
    logic signed [33:0]          delta_reg;

    logic               hit_x;
    logic               hit_y;
    logic               ax;
    logic [31:0]        diff;
    logic signed [33:0] d_raw;
    logic signed [33:0] d_fix;
    logic signed [48:0] sum;

    always_comb
    begin
        hit_x = (bus == axis_buses[0]) && (frame_id == {3'b000, x_node})
             && (length_byte == TEO_LEN_POS) && (node_byte == x_node)
             && (command_byte == TEO_CMD_POS);
        hit_y = (bus == axis_buses[1]) && (frame_id == {3'b000, y_node})
             && (length_byte == TEO_LEN_POS) && (node_byte == y_node)
             && (command_byte == TEO_CMD_POS);
        ax    = !hit_x;
        diff  = raw_count - last_reg[ax];
        d_raw = 34'(signed'(diff));
        priority if (d_raw > HALF_S)
            d_fix = d_raw - RANGE_S;
        else if (d_raw < -HALF_S)
            d_fix = d_raw + RANGE_S;
        else
            d_fix = d_raw;
        sum = 49'(total_reg[match_reg.axis]) + 49'(delta_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg[0]  <= 1'b0;
            seen_reg[1]  <= 1'b0;
            last_reg[0]  <= '0;
            last_reg[1]  <= '0;
            total_reg[0] <= '0;
            total_reg[1] <= '0;
            match_reg    <= '0;
            delta_reg    <= '0;
        end
        else
        begin
            if (start)
            begin
                match_reg.taken <= hit_x || hit_y;
                match_reg.axis  <= !hit_x && hit_y;
                delta_reg       <= seen_reg[ax] ? d_fix : '0;
                if (hit_x || hit_y)
                begin
                    seen_reg[ax] <= 1'b1;
                    last_reg[ax] <= raw_count;
                end
            end
            if (commit && match_reg.taken)
            begin
                // clamp the total to the 48-bit signed range
                if (sum[48] != sum[47])
                    total_reg[match_reg.axis] <= {sum[48], {(TEO_TOT_W-1){!sum[48]}}};
                else
                    total_reg[match_reg.axis] <= sum[TEO_TOT_W-1:0];
            end
        end
    end

    assign match   = match_reg;
    assign total_x = total_reg[0];
    assign total_y = total_reg[1];

endmodule

### src/two_axis_encoder_odometry.sv
// Two-axis encoder odometry: one frame in, one result out.
// Every multiply of the item (four for distances, four for projections) runs
// through one shared registered multiplier under the sequencer below, and a
// new frame is accepted only in the idle state, once the previous result has
// moved to the output register. A finished result waits in the output
// register while the next frame is taken.
// Reset clears totals, seen flags and config to defaults.
`timescale 1ns / 1ps

module two_axis_encoder_odometry
    import teo_pkg::*;
#(
    parameter logic [32:0] RAW_COUNT_RANGE = TEO_RAW_COUNT_RANGE
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // frame_id, length_byte, node_byte, command_byte,
                                   // raw_count, zero pad
    input  logic        s_tuser,   // bus
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // axis_distance, chassis_x, chassis_y
    output logic [1:0]  m_tuser,   // frame_taken, matched_axis
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MATCH, S_COMMIT, S_D_HI, S_D_LO, S_D_SUM, S_D_CLAMP,
        S_P_A, S_P_B, S_P_SUM, S_P_OUT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   sel_reg;
    logic   m_valid_reg;

    logic [1:0]  axis_buses_reg;
    logic [7:0]  x_node_reg;
    logic [7:0]  y_node_reg;
    logic [31:0] mpc_reg;
    logic signed [15:0] cos_x_reg, sin_x_reg, cos_y_reg, sin_y_reg;

    logic        bus_reg;
    logic [10:0] frame_id_reg;
    logic [7:0]  length_reg, node_reg, command_reg;
    logic [31:0] count_reg;

    logic signed [TEO_MUL_PW-1:0] acc_reg;
    logic                         neg_reg;
    logic signed [31:0]           dx_reg, dy_reg, chx_reg, chy_reg;
    logic [95:0]                  m_data_reg;
    logic [1:0]                   m_user_reg;

    teo_match_t                   match;
    logic signed [TEO_TOT_W-1:0]  total_x, total_y;
    logic signed [TEO_TOT_W-1:0]  tot_sel;
    logic                         tot_neg;
    logic [TEO_TOT_W-1:0]         mag;
    logic signed [TEO_MUL_AW-1:0] mul_a;
    logic signed [TEO_MUL_BW-1:0] mul_b;
    logic signed [TEO_MUL_PW-1:0] prod;
    logic signed [TEO_MUL_PW-1:0] proj_sh;
    logic signed [31:0]           dist_clamp;
    logic signed [31:0]           proj_sat;
    logic signed [31:0]           axis_dist;
    logic                         out_free;

    teo_track #(
        .RAW_COUNT_RANGE (RAW_COUNT_RANGE)
    ) u_track (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (state_reg == S_MATCH),
        .commit         (state_reg == S_COMMIT),
        .bus            (bus_reg),
        .frame_id       (frame_id_reg),
        .length_byte    (length_reg),
        .node_byte      (node_reg),
        .command_byte   (command_reg),
        .raw_count      (count_reg),
        .axis_buses     (axis_buses_reg),
        .x_node         (x_node_reg),
        .y_node         (y_node_reg),
        .match          (match),
        .total_x        (total_x),
        .total_y        (total_y)
    );

    teo_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;

    // operand select for the shared multiplier
    always_comb
    begin
        tot_sel = sel_reg ? total_y : total_x;
        tot_neg = tot_sel[TEO_TOT_W-1];
        mag     = tot_neg ? TEO_TOT_W'(-tot_sel) : TEO_TOT_W'(tot_sel);
        mul_a   = '0;
        mul_b   = '0;
        unique case (state_reg)
            S_D_HI:
            begin
                mul_a = signed'({1'b0, mag});
                mul_b = signed'({1'b0, mpc_reg[31:16]});
            end
            S_D_LO:
            begin
                mul_a = signed'({1'b0, mag});
                mul_b = signed'({1'b0, mpc_reg[15:0]});
            end
            S_P_A:
            begin
                mul_a = TEO_MUL_AW'(dx_reg);
                mul_b = TEO_MUL_BW'(sel_reg ? sin_x_reg : cos_x_reg);
            end
            S_P_B:
            begin
                mul_a = TEO_MUL_AW'(dy_reg);
                mul_b = TEO_MUL_BW'(sel_reg ? sin_y_reg : cos_y_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // distance clamp from the magnitude product, projection floor and saturate
    always_comb
    begin
        if (neg_reg)
        begin
            if (acc_reg > TEO_MUL_PW'(64'h8000_0000))
                dist_clamp = 32'sh8000_0000;
            else
                dist_clamp = -signed'(acc_reg[31:0]);
        end
        else
        begin
            if (acc_reg > TEO_MUL_PW'(64'h7FFF_FFFF))
                dist_clamp = 32'sh7FFF_FFFF;
            else
                dist_clamp = signed'(acc_reg[31:0]);
        end
        proj_sh = acc_reg >>> 15;
        priority if (proj_sh > TEO_MUL_PW'(32'sh7FFF_FFFF))
            proj_sat = 32'sh7FFF_FFFF;
        else if (proj_sh < TEO_MUL_PW'(32'sh8000_0000))
            proj_sat = 32'sh8000_0000;
        else
            proj_sat = proj_sh[31:0];
        axis_dist = match.taken ? (match.axis ? dy_reg : dx_reg) : 32'sd0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (s_tvalid) state_next = S_MATCH;
            S_MATCH:   state_next = S_COMMIT;
            S_COMMIT:  state_next = S_D_HI;
            S_D_HI:    state_next = S_D_LO;
            S_D_LO:    state_next = S_D_SUM;
            S_D_SUM:   state_next = S_D_CLAMP;
            S_D_CLAMP: state_next = sel_reg ? S_P_A : S_D_HI;
            S_P_A:     state_next = S_P_B;
            S_P_B:     state_next = S_P_SUM;
            S_P_SUM:   state_next = S_P_OUT;
            S_P_OUT:   state_next = sel_reg ? S_DONE : S_P_A;
            S_DONE:    if (out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            sel_reg        <= 1'b0;
            m_valid_reg    <= 1'b0;
            axis_buses_reg <= 2'd0;
            x_node_reg     <= 8'd1;
            y_node_reg     <= 8'd2;
            mpc_reg        <= 32'd0;
            cos_x_reg      <= 16'sd32767;
            sin_x_reg      <= 16'sd0;
            cos_y_reg      <= 16'sd0;
            sin_y_reg      <= 16'sd32767;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_D_CLAMP || state_reg == S_P_OUT)
                sel_reg <= !sel_reg;
            if (state_reg == S_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (teo_reg_t'(cfg_index))
                    REG_AXIS_BUSES: axis_buses_reg <= cfg_data[1:0];
                    REG_X_NODE:     x_node_reg     <= cfg_data[7:0];
                    REG_Y_NODE:     y_node_reg     <= cfg_data[7:0];
                    REG_MPC:        mpc_reg        <= cfg_data;
                    REG_COS_X:      cos_x_reg      <= signed'(cfg_data[15:0]);
                    REG_SIN_X:      sin_x_reg      <= signed'(cfg_data[15:0]);
                    REG_COS_Y:      cos_y_reg      <= signed'(cfg_data[15:0]);
                    REG_SIN_Y:      sin_y_reg      <= signed'(cfg_data[15:0]);
                    default:        mpc_reg        <= mpc_reg;
                endcase
            end
        end
    end

    // datapath: input capture, accumulator, per-item results
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && s_tvalid)
        begin
            bus_reg      <= s_tuser;
            frame_id_reg <= s_tdata[10:0];
            length_reg   <= s_tdata[18:11];
            node_reg     <= s_tdata[26:19];
            command_reg  <= s_tdata[34:27];
            count_reg    <= s_tdata[66:35];
        end
        unique case (state_reg)
            S_D_HI:    neg_reg <= tot_neg;
            S_D_LO:    acc_reg <= prod;
            S_D_SUM:   acc_reg <= acc_reg + (prod >>> 16);
            S_D_CLAMP:
            begin
                if (sel_reg)
                    dy_reg <= dist_clamp;
                else
                    dx_reg <= dist_clamp;
            end
            S_P_B:     acc_reg <= prod;
            S_P_SUM:   acc_reg <= acc_reg + prod;
            S_P_OUT:
            begin
                if (sel_reg)
                    chy_reg <= proj_sat;
                else
                    chx_reg <= proj_sat;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    m_data_reg <= {chy_reg, chx_reg, axis_dist};
                    m_user_reg <= {match.axis & match.taken, match.taken};
                end
            end
            default:   acc_reg <= acc_reg;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

### test/odo_checker.sv
// Scoreboard for the two-axis encoder odometry block: watches the frame, result
// and register-write channels, predicts every result and compares it field by field.
// Depends on teo_pkg for register indexes and frame constants.
`timescale 1ns / 1ps

module odo_checker
    import teo_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [71:0] s_tdata,   // frame_id, length_byte, node_byte, command_byte,
                                   // raw_count, zero pad
    input  logic        s_tuser,   // bus
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,   // axis_distance, chassis_x, chassis_y
    input  logic [1:0]  m_tuser,   // frame_taken, matched_axis
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output int          fail_count,
    output int          results_owed
);

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam longint TOTAL_HI = 64'sd140737488355327;
    localparam longint TOTAL_LO = -TOTAL_HI - 64'sd1;
    localparam longint HALF_RANGE = longint'(TEO_RAW_COUNT_RANGE) / 2;

    typedef struct {
        logic        taken;
        logic        axis;
        logic [31:0] dist_q;
        logic [31:0] chx;
        logic [31:0] chy;
    } odo_result_t;

    // register copies
    logic [1:0]         buses;
    logic [7:0]         node_id [2];
    logic [31:0]        mpc;
    logic signed [15:0] cos_x, sin_x, cos_y, sin_y;

    // per-axis odometry state
    logic        seen [2];
    logic [31:0] last_cnt [2];
    longint      total [2];

    odo_result_t owed_q [$];

    function automatic logic [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // total counts times Q0.32 metres per count, scaled to Q16.16, magnitude truncated
    function automatic logic [31:0] metres_of(input longint t);
        longint unsigned mag;
        longint unsigned q;
        mag = (t < 0) ? -t : t;
        q = mag * mpc[31:16] + ((mag * mpc[15:0]) >> 16);
        return clamp32((t < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic logic [31:0] project_q15(input logic signed [31:0] da,
                                                input logic signed [15:0] ca,
                                                input logic signed [31:0] db,
                                                input logic signed [15:0] cb);
        longint acc;
        acc = longint'(da) * longint'(ca) + longint'(db) * longint'(cb);
        return clamp32(acc >>> 15);
    endfunction

    function automatic logic axis_hit(input int ax, input logic [71:0] d, input logic bus);
        return bus == buses[ax] && d[10:0] == {3'b000, node_id[ax]} &&
               d[18:11] == TEO_LEN_POS && d[26:19] == node_id[ax] &&
               d[34:27] == TEO_CMD_POS;
    endfunction

    function automatic void take_count(input int ax, input logic [31:0] cnt);
        logic [31:0] diff;
        longint      d;
        if (!seen[ax])
        begin
            seen[ax] = 1'b1;
            last_cnt[ax] = cnt;
            return;
        end
        diff = cnt - last_cnt[ax];
        d = longint'($signed(diff));
        last_cnt[ax] = cnt;
        if (d > HALF_RANGE)
            d -= longint'(TEO_RAW_COUNT_RANGE);
        else if (d < -HALF_RANGE)
            d += longint'(TEO_RAW_COUNT_RANGE);
        d += total[ax];
        if (d > TOTAL_HI)
            d = TOTAL_HI;
        if (d < TOTAL_LO)
            d = TOTAL_LO;
        total[ax] = d;
    endfunction

    function automatic odo_result_t predict_frame(input logic [71:0] d, input logic bus);
        odo_result_t r;
        logic [31:0] dx, dy;
        int          ax;
        ax = -1;
        if (axis_hit(AX_X, d, bus))
            ax = AX_X;
        else if (axis_hit(AX_Y, d, bus))
            ax = AX_Y;
        if (ax >= 0)
            take_count(ax, d[66:35]);
        dx = metres_of(total[AX_X]);
        dy = metres_of(total[AX_Y]);
        r.taken  = (ax >= 0);
        r.axis   = (ax == AX_Y);
        r.dist_q = (ax == AX_X) ? dx : (ax == AX_Y) ? dy : 32'd0;
        r.chx    = project_q15(dx, cos_x, dy, cos_y);
        r.chy    = project_q15(dx, sin_x, dy, sin_y);
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        odo_result_t want;
        if (!rst_n)
        begin
            buses = 2'b00;
            node_id[AX_X] = 8'd1;
            node_id[AX_Y] = 8'd2;
            mpc = 32'd0;
            cos_x = 16'sd32767;
            sin_x = 16'sd0;
            cos_y = 16'sd0;
            sin_y = 16'sd32767;
            for (int i = 0; i < 2; i++)
            begin
                seen[i] = 1'b0;
                last_cnt[i] = 32'd0;
                total[i] = 0;
            end
            owed_q.delete();
            fail_count = 0;
            results_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (teo_reg_t'(cfg_index))
                    REG_AXIS_BUSES: buses = cfg_data[1:0];
                    REG_X_NODE:     node_id[AX_X] = cfg_data[7:0];
                    REG_Y_NODE:     node_id[AX_Y] = cfg_data[7:0];
                    REG_MPC:        mpc = cfg_data;
                    REG_COS_X:      cos_x = cfg_data[15:0];
                    REG_SIN_X:      sin_x = cfg_data[15:0];
                    REG_COS_Y:      cos_y = cfg_data[15:0];
                    REG_SIN_Y:      sin_y = cfg_data[15:0];
                    default: ;
                endcase
            end
            // compare before pushing: a result beat never answers the frame of the same edge
            if (m_tvalid === 1'b1 && m_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result beat expected none actual %h %h",
                             $time, m_tuser, m_tdata);
                end
                else
                begin
                    want = owed_q.pop_front();
                    compare_field("frame_taken", 32'(want.taken), 32'(m_tuser[0]));
                    compare_field("matched_axis", 32'(want.axis), 32'(m_tuser[1]));
                    compare_field("axis_distance", want.dist_q, m_tdata[31:0]);
                    compare_field("chassis_x", want.chx, m_tdata[63:32]);
                    compare_field("chassis_y", want.chy, m_tdata[95:64]);
                end
            end
            if (s_tvalid && s_tready)
                owed_q.push_back(predict_frame(s_tdata, s_tuser));
            results_owed = owed_q.size();
        end
    end

endmodule

### test/tb.sv
// Top of the odometry testbench: clock, reset, frame and register stimulus,
// receiver stalls and the verdict. Depends on teo_pkg, odo_checker and the block.
`timescale 1ns / 1ps

module tb;
    import teo_pkg::*;

    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int RAND_PHASES = 6;
    localparam int PHASE_ITEMS = 292;
    localparam logic [31:0] HALF_CNT = 32'h0080_0000;

    typedef struct {
        logic        bus;
        logic [10:0] id;
        logic [7:0]  len;
        logic [7:0]  node;
        logic [7:0]  cmd;
        logic [31:0] count;
    } odo_frame_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // frame_id, length_byte, node_byte, command_byte,
                            // raw_count, zero pad
    logic        s_tuser;   // bus
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;   // axis_distance, chassis_x, chassis_y
    logic [1:0]  m_tuser;   // frame_taken, matched_axis
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          results_owed;

    bit          idle_on;
    int          stall_left;
    logic [1:0]  cur_buses;
    logic [7:0]  cur_node [2];
    logic [31:0] sent_cnt [2];

    two_axis_encoder_odometry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    odo_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 4);
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input teo_reg_t idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_AXIS_BUSES: cur_buses = val[1:0];
            REG_X_NODE:     cur_node[AX_X] = val[7:0];
            REG_Y_NODE:     cur_node[AX_Y] = val[7:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [1:0] buses, input logic [7:0] xn,
                               input logic [7:0] yn, input logic [31:0] mpc,
                               input logic [15:0] cx, input logic [15:0] sx,
                               input logic [15:0] cy, input logic [15:0] sy);
        write_reg(REG_AXIS_BUSES, {30'd0, buses});
        write_reg(REG_X_NODE, {24'd0, xn});
        write_reg(REG_Y_NODE, {24'd0, yn});
        write_reg(REG_MPC, mpc);
        write_reg(REG_COS_X, {16'd0, cx});
        write_reg(REG_SIN_X, {16'd0, sx});
        write_reg(REG_COS_Y, {16'd0, cy});
        write_reg(REG_SIN_Y, {16'd0, sy});
        cfg_valid <= 1'b0;
    endtask

    // hold off until every owed result has come back
    task automatic wait_drained();
        do @(posedge clk); while (results_owed != 0);
        repeat (24) @(posedge clk);
    endtask

    task automatic send_frame(input odo_frame_t f);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tuser <= f.bus;
        s_tdata <= {5'd0, f.count, f.cmd, f.node, f.len, f.id};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    function automatic odo_frame_t well_formed(input int ax, input logic [31:0] cnt);
        odo_frame_t f;
        f.bus = cur_buses[ax];
        f.id = {3'b000, cur_node[ax]};
        f.len = TEO_LEN_POS;
        f.node = cur_node[ax];
        f.cmd = TEO_CMD_POS;
        f.count = cnt;
        return f;
    endfunction

    task automatic send_position(input int ax, input logic [31:0] cnt);
        sent_cnt[ax] = cnt;
        send_frame(well_formed(ax, cnt));
    endtask

    function automatic logic [31:0] count_step();
        case ($urandom_range(0, 4))
            0: return $urandom_range(0, 4000) - 32'd2000;
            1: return HALF_CNT + $urandom_range(0, 4) - 32'd2;
            2: return -HALF_CNT + $urandom_range(0, 4) - 32'd2;
            3: return $urandom;
            default: return $urandom_range(0, 32'h00FF_FFFF) - HALF_CNT;
        endcase
    endfunction

    function automatic logic [15:0] pick_q15();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_setup(input int ph);
        logic [7:0]  xn;
        logic [7:0]  yn;
        logic [31:0] mpc;
        xn = 8'($urandom_range(0, 255));
        yn = ($urandom_range(0, 4) == 0) ? xn : 8'($urandom_range(0, 255));
        case (ph % 4)
            0: mpc = $urandom_range(0, 32'h0003_FFFF);
            1: mpc = $urandom;
            2: mpc = 32'hFFFF_FFFF;
            default: mpc = {8'd0, 8'($urandom_range(0, 255)), 16'($urandom)};
        endcase
        load_config(2'($urandom_range(0, 3)), xn, yn, mpc,
                    pick_q15(), pick_q15(), pick_q15(), pick_q15());
    endtask

    task automatic random_frame();
        odo_frame_t f;
        int         ax;
        int         pick;
        ax = $urandom_range(AX_X, AX_Y);
        pick = $urandom_range(0, 99);
        if (pick < 70)
            send_position(ax, sent_cnt[ax] + count_step());
        else if (pick < 85)
        begin
            // break one field of an otherwise good frame
            f = well_formed(ax, $urandom);
            case ($urandom_range(0, 5))
                0: f.bus = ~f.bus;
                1: f.id[10:8] = 3'($urandom_range(1, 7));
                2: f.len = 8'($urandom);
                3: f.node = f.node ^ 8'($urandom_range(1, 255));
                4: f.cmd = 8'($urandom);
                default: f.id = 11'($urandom);
            endcase
            send_frame(f);
        end
        else
        begin
            f.bus = 1'($urandom);
            f.id = 11'($urandom);
            f.len = 8'($urandom);
            f.node = 8'($urandom);
            f.cmd = 8'($urandom);
            f.count = $urandom;
            send_frame(f);
        end
    endtask

    initial
    begin
        odo_frame_t f;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_AXIS_BUSES;
        cfg_data = '0;
        idle_on = 1'b1;
        stall_left = 0;
        cur_buses = 2'b00;
        cur_node[AX_X] = 8'd1;
        cur_node[AX_Y] = 8'd2;
        sent_cnt[AX_X] = '0;
        sent_cnt[AX_Y] = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: first frame only records, second wraps through zero
        send_position(AX_X, 32'hFFFF_FFF0);
        send_position(AX_X, 32'h0000_0010);
        send_position(AX_Y, 32'h1234_5678);
        f = well_formed(AX_X, 32'h0000_0100);
        f.id = 11'h701;   // node id must match the full 11-bit identifier
        send_frame(f);
        s_tvalid <= 1'b0;
        wait_drained();

        load_config(2'b10, 8'h00, 8'hFF, 32'hFFFF_FFFF,
                    16'h8000, 16'h7FFF, 16'h8000, 16'h8000);
        send_position(AX_X, sent_cnt[AX_X] + HALF_CNT);
        send_position(AX_X, sent_cnt[AX_X] + HALF_CNT + 32'd1);
        send_position(AX_X, sent_cnt[AX_X] - HALF_CNT - 32'd1);
        send_position(AX_Y, sent_cnt[AX_Y] + 32'h0000_1234);
        send_position(AX_Y, sent_cnt[AX_Y] - HALF_CNT);
        f = well_formed(AX_Y, 32'h0000_0000);
        f.bus = 1'b0;
        send_frame(f);
        f = well_formed(AX_Y, 32'hFFFF_FFFF);
        f.len = 8'hFF;
        send_frame(f);
        f.len = 8'h00;
        send_frame(f);
        f = well_formed(AX_X, 32'h5555_AAAA);
        f.cmd = 8'h00;
        send_frame(f);
        f.cmd = 8'hFF;
        send_frame(f);
        f = well_formed(AX_Y, 32'hAAAA_5555);
        f.node = 8'hFE;
        send_frame(f);
        f.node = 8'hFF;
        f.id = 11'h7FF;
        send_frame(f);
        s_tvalid <= 1'b0;
        wait_drained();

        // both axes on one node and bus: x takes the frame
        load_config(2'b00, 8'h33, 8'h33, 32'h0001_0000,
                    16'h7FFF, 16'h0000, 16'h0000, 16'h7FFF);
        send_position(AX_X, sent_cnt[AX_X] + 32'd500);
        send_position(AX_X, sent_cnt[AX_X] - 32'd1500);
        send_position(AX_X, sent_cnt[AX_X] + 32'd7);
        s_tvalid <= 1'b0;
        wait_drained();
        sent_cnt[AX_Y] = sent_cnt[AX_X];

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_on = 1'b1;
            random_setup(ph);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                idle_on = (ph != RAND_PHASES - 1) && ((k % 120) < 90);
                random_frame();
            end
            s_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
